FILE: hdl/greedy_iou_box_dedup_assert.svh
// Assertion macros shared by the greedy IoU box dedup modules.
`ifndef GREEDY_IOU_BOX_DEDUP_ASSERT_SVH
`define GREEDY_IOU_BOX_DEDUP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check an implication or any other property on every clock edge out of reset.
`define GBD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
// Check that a condition never holds.
`define GBD_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);
`else
`define GBD_ASSERT(label, prop, msg)
`define GBD_NEVER(label, cond, msg)
`endif
`endif

FILE: hdl/gbd_pkg.sv
// Package: constants and controller/datapath interface types for the box dedup block.
package gbd_pkg;

	localparam int MAX_KEPT_DEF   = 32;
	localparam int COORD_BITS_DEF = 16;
	localparam int THR_W          = 17;
	localparam int FRAC_BITS      = 16;
	localparam logic [THR_W-1:0] THR_RESET = 17'd32768;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;    // capture the accepted box
		logic setup;   // compute the area of the new box
		logic issue;   // read the next kept box into the compare pipeline
		logic finish;  // store the verdict and load the output register
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic cnt_zero;    // kept table is empty
		logic last_issue;  // current read index is the last kept entry
		logic pipe_busy;   // compare pipeline still holds entries
		logic out_free;    // output register can take a result this cycle
	} sts_t;

endpackage

FILE: hdl/gbd_ctrl.sv
// Controller: sequences capture, table scan, pipeline drain and result hand-off.
`include "greedy_iou_box_dedup_assert.svh"

module gbd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  gbd_pkg::sts_t sts,
	output gbd_pkg::cmd_t cmd
);
	import gbd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SETUP = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// Decode commands and next state
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = sts.cnt_zero ? ST_DRAIN : ST_SCAN;
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy && sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`GBD_ASSERT(a_accept_to_setup, (s_tvalid && s_tready) |=> (state_q == ST_SETUP), "accepted box did not enter setup")
	`GBD_ASSERT(a_last_issue_drains, (state_q == ST_SCAN && sts.last_issue) |=> (state_q == ST_DRAIN), "scan did not stop after the last entry")
	`GBD_NEVER(a_idle_pipe_empty, state_q == ST_IDLE && sts.pipe_busy, "compare pipeline busy while idle")

endmodule

FILE: hdl/gbd_dp.sv
// Datapath: threshold register, kept-box memory, pipelined IoU compare and output register.
`include "greedy_iou_box_dedup_assert.svh"

module gbd_dp #(
	parameter int MAX_KEPT   = gbd_pkg::MAX_KEPT_DEF,
	parameter int COORD_BITS = gbd_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [gbd_pkg::THR_W-1:0]     cfg_wdata,
	input  gbd_pkg::cmd_t                 cmd,
	output gbd_pkg::sts_t                 sts,
	input  logic signed [COORD_BITS-1:0]  box_left,
	input  logic signed [COORD_BITS-1:0]  box_top,
	input  logic signed [COORD_BITS-1:0]  box_right,
	input  logic signed [COORD_BITS-1:0]  box_bottom,
	input  logic                          first_of_list,
	input  logic                          last_of_list,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output logic                          keep,
	output logic signed [COORD_BITS-1:0]  out_left,
	output logic signed [COORD_BITS-1:0]  out_top,
	output logic signed [COORD_BITS-1:0]  out_right,
	output logic signed [COORD_BITS-1:0]  out_bottom,
	output logic                          end_of_list,
	output logic                          table_full
);
	import gbd_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int IW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CW = $clog2(MAX_KEPT + 1);
	localparam int BW = 4 * CB;
	localparam int SW = CB + 2;           // inclusive width or height, signed
	localparam int AW = 2 * CB + 2;       // area, signed
	localparam int UW = 2 * CB + 3;       // union, signed
	localparam int PW = THR_W + UW - 1;   // threshold times positive union
	localparam logic signed [SW-1:0] ONE_S = 1;

	// Threshold register
	logic [THR_W-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wen) begin
			thr_q <= cfg_wdata;
		end
	end

	// Capture the new box and its inclusive width and height
	logic signed [CB-1:0] nl_q, nt_q, nr_q, nb_q;
	logic                 last_q;
	logic signed [SW-1:0] nw_q, nh_q;
	logic signed [SW-1:0] nw_c, nh_c;

	assign nw_c = box_right - box_left + ONE_S;
	assign nh_c = box_bottom - box_top + ONE_S;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			nl_q   <= box_left;
			nt_q   <= box_top;
			nr_q   <= box_right;
			nb_q   <= box_bottom;
			last_q <= last_of_list;
			nw_q   <= nw_c;
			nh_q   <= nh_c;
		end
	end

	// New box area, once per box
	logic signed [AW+1:0] narea_full;
	logic signed [AW-1:0] narea_q;

	assign narea_full = nw_q * nh_q;

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			narea_q <= narea_full[AW-1:0];
		end
	end

	// Kept count, read index and verdict
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] idx_q;
	logic          keep_q;
	logic          cnt_full;
	logic          hit;
	logic          v4_s4;

	assign cnt_full = (cnt_q == CW'(MAX_KEPT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			idx_q  <= '0;
			keep_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q  <= '0;
				keep_q <= 1'b1;
				if (first_of_list) begin
					cnt_q <= '0;
				end
			end else begin
				if (cmd.issue) begin
					idx_q <= idx_q + IW'(1);
				end
				if (v4_s4 && hit) begin
					keep_q <= 1'b0;
				end
				if (cmd.finish && keep_q && !cnt_full) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	// Kept-box memory: one write port, one registered read port
	logic [BW-1:0] mem [MAX_KEPT];
	logic [BW-1:0] rd_s0;

	always_ff @(posedge clk) begin
		if (cmd.finish && keep_q && !cnt_full) begin
			mem[cnt_q[IW-1:0]] <= {nb_q, nr_q, nt_q, nl_q};
		end
		if (cmd.issue) begin
			rd_s0 <= mem[idx_q];
		end
	end

	// Pipeline valid bits
	logic v0_s0, v1_s1, v2_s2, v3_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_s0 <= 1'b0;
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			v0_s0 <= cmd.issue;
			v1_s1 <= v0_s0;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
		end
	end

	// Stage 1: overlap spans and kept-box width and height
	logic signed [CB-1:0] kl, kt, kr, kb;
	logic signed [CB-1:0] mn_r, mx_l, mn_b, mx_t;
	logic signed [CB:0]   ix_c, iy_c;
	logic signed [SW-1:0] kw_c, kh_c;
	logic [CB-1:0]        ix_s1, iy_s1;
	logic                 ovl_s1;
	logic signed [SW-1:0] kw_s1, kh_s1;

	assign kl   = rd_s0[CB-1:0];
	assign kt   = rd_s0[2*CB-1:CB];
	assign kr   = rd_s0[3*CB-1:2*CB];
	assign kb   = rd_s0[4*CB-1:3*CB];
	assign mn_r = (nr_q < kr) ? nr_q : kr;
	assign mx_l = (nl_q > kl) ? nl_q : kl;
	assign mn_b = (nb_q < kb) ? nb_q : kb;
	assign mx_t = (nt_q > kt) ? nt_q : kt;
	assign ix_c = mn_r - mx_l;
	assign iy_c = mn_b - mx_t;
	assign kw_c = kr - kl + ONE_S;
	assign kh_c = kb - kt + ONE_S;

	always_ff @(posedge clk) begin
		ix_s1  <= ix_c[CB-1:0];
		iy_s1  <= iy_c[CB-1:0];
		ovl_s1 <= !ix_c[CB] && (ix_c != '0) && !iy_c[CB] && (iy_c != '0);
		kw_s1  <= kw_c;
		kh_s1  <= kh_c;
	end

	// Stage 2: intersection and kept-box area
	logic [2*CB-1:0]      inter_c;
	logic signed [AW+1:0] karea_full;
	logic [2*CB-1:0]      inter_s2;
	logic signed [AW-1:0] karea_s2;
	logic                 ovl_s2;

	assign inter_c    = ix_s1 * iy_s1;
	assign karea_full = kw_s1 * kh_s1;

	always_ff @(posedge clk) begin
		inter_s2 <= inter_c;
		karea_s2 <= karea_full[AW-1:0];
		ovl_s2   <= ovl_s1;
	end

	// Stage 3: union and its sign
	logic signed [UW-1:0] uni_c;
	logic [UW-2:0]        uni_s3;
	logic [2*CB-1:0]      inter_s3;
	logic                 test_s3;

	assign uni_c = narea_q + karea_s2 - $signed({1'b0, inter_s2});

	always_ff @(posedge clk) begin
		uni_s3   <= uni_c[UW-2:0];
		inter_s3 <= inter_s2;
		test_s3  <= ovl_s2 && !uni_c[UW-1] && (uni_c != '0);
	end

	// Stage 4: threshold times union
	logic [PW-1:0]   rhs_c;
	logic [PW-1:0]   rhs_s4;
	logic [2*CB-1:0] inter_s4;
	logic            test_s4;

	assign rhs_c = thr_q * uni_s3;

	always_ff @(posedge clk) begin
		rhs_s4   <= rhs_c;
		inter_s4 <= inter_s3;
		test_s4  <= test_s3;
	end

	// Compare: drop when the threshold is zero or intersection * 2^16 reaches threshold * union
	logic [PW-1:0] lhs_c;

	assign lhs_c = PW'({inter_s4, {FRAC_BITS{1'b0}}});
	assign hit   = (thr_q == '0) || (test_s4 && (lhs_c >= rhs_s4));

	// Output register
	logic                 m_tvalid_q;
	logic                 out_keep_q, out_full_q, out_last_q;
	logic signed [CB-1:0] ol_q, ot_q, or_q, ob_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_keep_q <= keep_q;
			out_full_q <= keep_q && cnt_full;
			out_last_q <= last_q;
			ol_q       <= nl_q;
			ot_q       <= nt_q;
			or_q       <= nr_q;
			ob_q       <= nb_q;
		end
	end

	assign m_tvalid    = m_tvalid_q;
	assign keep        = out_keep_q;
	assign table_full  = out_full_q;
	assign end_of_list = out_last_q;
	assign out_left    = ol_q;
	assign out_top     = ot_q;
	assign out_right   = or_q;
	assign out_bottom  = ob_q;

	// Status to controller
	assign sts.cnt_zero   = (cnt_q == '0);
	assign sts.last_issue = ((CW'(idx_q) + CW'(1)) == cnt_q);
	assign sts.pipe_busy  = v0_s0 | v1_s1 | v2_s2 | v3_s3 | v4_s4;
	assign sts.out_free   = !m_tvalid_q || m_tready;

	`GBD_NEVER(a_cnt_in_range, cnt_q > CW'(MAX_KEPT), "kept count beyond table size")
	`GBD_ASSERT(a_issue_below_cnt, cmd.issue |-> (CW'(idx_q) < cnt_q), "read of an entry past the kept count")
	`GBD_NEVER(a_full_needs_keep, m_tvalid_q && out_full_q && !out_keep_q, "table full flag on a dropped box")

endmodule

FILE: hdl/greedy_iou_box_dedup.sv
// Greedy IoU box dedup: each box is checked against the kept boxes of its list.
// After an input transfer the kept boxes are read one a cycle (none with an empty table),
// then the five-stage compare pipeline drains and the verdict loads the output register.
// The next box is accepted only after that; a result held in the output register stalls
// the next box.
// arst_n clears state, count and valids, sets the threshold to 0.5; table memory is not cleared.
module greedy_iou_box_dedup #(
	parameter int MAX_KEPT   = gbd_pkg::MAX_KEPT_DEF,
	parameter int COORD_BITS = gbd_pkg::COORD_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// threshold register write
	input  logic                                    cfg_wen,
	input  logic [gbd_pkg::THR_W-1:0]               cfg_wdata,
	// input boxes
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]       s_tdata,  // box_left, box_top, box_right, box_bottom
	input  logic [0:0]                              s_tuser,  // first_of_list
	input  logic                                    s_tlast,  // last_of_list
	// judged boxes
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [((4*COORD_BITS+7)/8)*8-1:0]       m_tdata,  // out_left, out_top, out_right, out_bottom
	output logic [1:0]                              m_tuser,  // keep, table_full
	output logic                                    m_tlast   // end_of_list
);
	import gbd_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int DW = ((4 * COORD_BITS + 7) / 8) * 8;

	cmd_t cmd;
	sts_t sts;

	logic                 keep_o, full_o, last_o;
	logic signed [CB-1:0] ol, ot, orr, ob;

	gbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gbd_dp #(
		.MAX_KEPT   (MAX_KEPT),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.sts           (sts),
		.box_left      (s_tdata[CB-1:0]),
		.box_top       (s_tdata[2*CB-1:CB]),
		.box_right     (s_tdata[3*CB-1:2*CB]),
		.box_bottom    (s_tdata[4*CB-1:3*CB]),
		.first_of_list (s_tuser[0]),
		.last_of_list  (s_tlast),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.keep          (keep_o),
		.out_left      (ol),
		.out_top       (ot),
		.out_right     (orr),
		.out_bottom    (ob),
		.end_of_list   (last_o),
		.table_full    (full_o)
	);

	// Pack the result
	assign m_tdata = DW'({ob, orr, ot, ol});
	assign m_tuser = {full_o, keep_o};
	assign m_tlast = last_o;

endmodule

FILE: tb/sv/greedy_iou_box_dedup_tb.sv
// Testbench for greedy_iou_box_dedup: directed and random box lists checked against a predictor.
`timescale 1ns / 1ps

module greedy_iou_box_dedup_tb;

	localparam int CW            = gbd_pkg::COORD_BITS_DEF;
	localparam int TABLE_DEPTH   = gbd_pkg::MAX_KEPT_DEF;
	localparam int DW            = ((4*CW+7)/8)*8;
	localparam int SETTLE_CYCLES = TABLE_DEPTH + 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int IDLE_PCT      = 13;

	typedef struct packed {
		logic signed [CW-1:0] bottom;
		logic signed [CW-1:0] right;
		logic signed [CW-1:0] top;
		logic signed [CW-1:0] left;
	} rect_t;

	typedef struct {
		rect_t rect;
		bit    keep;
		bit    full;
		bit    is_last;
	} verdict_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_wen   = 1'b0;
	logic [gbd_pkg::THR_W-1:0] cfg_wdata = '0;
	logic                    s_tvalid  = 1'b0;
	logic                    s_tready;
	logic [DW-1:0]           s_tdata   = '0;
	logic [0:0]              s_tuser   = '0;
	logic                    s_tlast   = 1'b0;
	logic                    m_tvalid;
	logic                    m_tready  = 1'b0;
	logic [DW-1:0]           m_tdata;
	logic [1:0]              m_tuser;
	logic                    m_tlast;

	// predictor state
	rect_t                     kept_table [TABLE_DEPTH];
	int                        kept_total  = 0;
	logic [gbd_pkg::THR_W-1:0] threshold_q = gbd_pkg::THR_RESET;
	verdict_t                  verdict_q [$];

	int   fail_count   = 0;
	logic no_idle      = 1'b0;
	logic hold_pending = 1'b0;

	greedy_iou_box_dedup uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Bound the run in case the block hangs
	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	// True if kept box k suppresses new box n under the current threshold
	function automatic bit suppresses(rect_t n, rect_t k);
		longint nl, nt, nr, nb, kl, kt, kr, kb, ix, iy, inter, uni;
		nl = n.left;
		nt = n.top;
		nr = n.right;
		nb = n.bottom;
		kl = k.left;
		kt = k.top;
		kr = k.right;
		kb = k.bottom;
		ix = ((nr < kr) ? nr : kr) - ((nl > kl) ? nl : kl);
		iy = ((nb < kb) ? nb : kb) - ((nt > kt) ? nt : kt);
		// no overlap and a degenerate union both count as IoU 0
		if (ix <= 0 || iy <= 0)
			return threshold_q == 0;
		inter = ix * iy;
		uni = (nr - nl + 1) * (nb - nt + 1) + (kr - kl + 1) * (kb - kt + 1) - inter;
		if (uni <= 0)
			return threshold_q == 0;
		return inter * 65536 >= longint'(threshold_q) * uni;
	endfunction

	// Judge one accepted box, update the kept table, queue the verdict
	function automatic void judge_box(rect_t box, bit is_first, bit is_last);
		verdict_t v;
		v.rect    = box;
		v.keep    = 1'b1;
		v.full    = 1'b0;
		v.is_last = is_last;
		if (is_first)
			kept_total = 0;
		for (int i = 0; i < kept_total; i++) begin
			if (suppresses(box, kept_table[i])) begin
				v.keep = 1'b0;
				break;
			end
		end
		if (v.keep) begin
			if (kept_total < TABLE_DEPTH) begin
				kept_table[kept_total] = box;
				kept_total++;
			end else begin
				v.full = 1'b1;
			end
		end
		verdict_q.insert(verdict_q.size(), v);
	endfunction

	// Offer one box until it is transferred, then predict its verdict
	task automatic send_box(int left, int top, int right, int bottom, bit is_first, bit is_last);
		rect_t box;
		box.left   = CW'(left);
		box.top    = CW'(top);
		box.right  = CW'(right);
		box.bottom = CW'(bottom);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= box;
		s_tuser  <= is_first;
		s_tlast  <= is_last;
		do
			@(posedge clk);
		while (!s_tready);
		judge_box(box, is_first, is_last);
	endtask

	// Hold the input quiet until every verdict is back and the block has settled
	task automatic wait_results();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (verdict_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the threshold register while the block is idle
	task automatic set_threshold(int unsigned value);
		wait_results();
		cfg_wen   <= 1'b1;
		cfg_wdata <= value[gbd_pkg::THR_W-1:0];
		@(posedge clk);
		cfg_wen     <= 1'b0;
		threshold_q = value[gbd_pkg::THR_W-1:0];
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Drive output ready: random stalls, idle-free stretches, long hold-offs on request
	always @(posedge clk) begin : drive_ready
		int hold_left;
		if (hold_pending) begin
			hold_left = HOLD_CYCLES;
			hold_pending <= 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Compare each output transfer with the oldest predicted verdict
	always @(posedge clk) begin : check_results
		verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual data %h user %b last %b",
					$time, m_tdata, m_tuser, m_tlast);
				fail_count++;
			end else begin
				want = verdict_q.pop_front();
				check_field("keep", want.keep, m_tuser[0]);
				check_field("table_full", want.full, m_tuser[1]);
				check_field("end_of_list", want.is_last, m_tlast);
				check_field("out_left", want.rect.left, $signed(m_tdata[CW-1:0]));
				check_field("out_top", want.rect.top, $signed(m_tdata[2*CW-1:CW]));
				check_field("out_right", want.rect.right, $signed(m_tdata[3*CW-1:2*CW]));
				check_field("out_bottom", want.rect.bottom, $signed(m_tdata[4*CW-1:3*CW]));
			end
		end
	end

	// Basic overlaps, edge coordinates, inverted boxes and flag combinations at reset threshold
	task automatic test_directed_cases();
		send_box(0, 0, 9, 9, 1'b1, 1'b0);                  // empty table: kept
		send_box(0, 0, 9, 9, 1'b0, 1'b0);                  // identical: suppressed
		send_box(5, 0, 14, 9, 1'b0, 1'b0);                 // IoU below one half
		send_box(10, 0, 19, 9, 1'b0, 1'b0);                // edges touch: no overlap
		send_box(100, 100, 100, 100, 1'b0, 1'b0);          // single point box
		send_box(-32768, -32768, 32767, 32767, 1'b0, 1'b0); // whole plane
		send_box(-32768, -32768, 32767, 32767, 1'b0, 1'b0); // same again: suppressed
		send_box(10, 10, 0, 0, 1'b0, 1'b0);                // inverted
		send_box(32767, 32767, -32768, -32768, 1'b0, 1'b1); // fully inverted, end of list
		send_box(-32768, 32767, 32767, -32768, 1'b1, 1'b1); // both flags
		send_box(-5, -5, 5, 5, 1'b0, 1'b0);                // list without a first flag
		send_box(-4, -5, 5, 5, 1'b0, 1'b0);
		send_box(-5, -5, 5, 5, 1'b1, 1'b0);                // first flag clears table
		send_box(-5, -5, 5, 4, 1'b0, 1'b1);
	endtask

	// Threshold at zero, one, exactly 1.0 and its maximum
	task automatic test_threshold_extremes();
		set_threshold(0);
		send_box(0, 0, 9, 9, 1'b1, 1'b0);
		send_box(1000, 1000, 1010, 1010, 1'b0, 1'b0);      // disjoint still suppressed
		send_box(0, 0, 9, 9, 1'b0, 1'b1);
		set_threshold(1);
		send_box(0, 0, 99, 99, 1'b1, 1'b0);
		send_box(98, 98, 200, 200, 1'b0, 1'b1);            // one-pixel overlap suppresses
		set_threshold(65536);
		send_box(0, 0, 9, 9, 1'b1, 1'b0);
		send_box(0, 0, 9, 9, 1'b0, 1'b1);                  // identical box kept
		set_threshold(131071);
		send_box(-32768, -32768, 32767, 32767, 1'b1, 1'b0);
		send_box(-32768, -32768, 32767, 32767, 1'b0, 1'b1);
		set_threshold(32768);
	endtask

	// Fill the kept table and run past it
	task automatic test_table_overflow();
		for (int i = 0; i < TABLE_DEPTH + 4; i++)
			send_box(i * 100, 0, i * 100 + 9, 9, i == 0, 1'b0);
		send_box(0, 0, 9, 9, 1'b0, 1'b0);                  // suppressed while full
		send_box(20000, 20000, 20010, 20010, 1'b0, 1'b1);
		send_box(0, 0, 9, 9, 1'b1, 1'b1);                  // fresh list stores again
		wait_results();
	endtask

	// Hold off the receiver while the sender keeps offering a list
	task automatic test_output_backpressure();
		no_idle      <= 1'b1;
		hold_pending <= 1'b1;
		for (int i = 0; i < 16; i++)
			send_box(i * 7, i * 3, i * 7 + 20, i * 3 + 20, i == 0, i == 15);
		no_idle <= 1'b0;
		wait_results();
	endtask

	// Random lists: clustered, scattered, near the coordinate limits, and noise
	task automatic test_random_lists(int n_items);
		int sent, len, mode, cx, cy, w, h, l, t, lists;
		bit is_first, is_last;
		sent  = 0;
		lists = 0;
		while (sent < n_items) begin
			// change the threshold every few lists
			if (lists % 8 == 7) begin
				case ($urandom_range(9))
					0:       set_threshold(0);
					1:       set_threshold(65536);
					2:       set_threshold(131071);
					3:       set_threshold($urandom_range(131071));
					4:       set_threshold($urandom_range(1, 4096));
					default: set_threshold($urandom_range(8000, 60000));
				endcase
			end
			if (sent >= 600 && sent < 1000)
				no_idle <= 1'b1;
			else
				no_idle <= 1'b0;
			len  = ($urandom_range(99) < 20) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			mode = $urandom_range(99);
			cx   = int'($urandom_range(65535)) - 32768;
			cy   = int'($urandom_range(65535)) - 32768;
			w    = $urandom_range(2, 60);
			h    = $urandom_range(2, 60);
			if (mode >= 90) begin
				cx = ($urandom_range(1)) ? 32767 - int'($urandom_range(30)) :
					-32768 + int'($urandom_range(30));
				cy = ($urandom_range(1)) ? 32767 - int'($urandom_range(30)) :
					-32768 + int'($urandom_range(30));
			end
			for (int i = 0; i < len; i++) begin
				is_first = (i == 0) ? ($urandom_range(99) < 92) : ($urandom_range(99) < 2);
				is_last  = (i == len - 1) ? ($urandom_range(99) < 90) : ($urandom_range(99) < 2);
				if (mode < 60 || mode >= 90) begin
					l = cx + int'($urandom_range(w)) - w / 2;
					t = cy + int'($urandom_range(h)) - h / 2;
					send_box(l, t, l + w + int'($urandom_range(w / 2)) - w / 4,
						t + h + int'($urandom_range(h / 2)) - h / 4, is_first, is_last);
				end else if (mode < 75) begin
					l = int'($urandom_range(65535)) - 32768;
					t = int'($urandom_range(65535)) - 32768;
					send_box(l, t, l + int'($urandom_range(8)), t + int'($urandom_range(8)),
						is_first, is_last);
				end else begin
					send_box($urandom_range(65535), $urandom_range(65535),
						$urandom_range(65535), $urandom_range(65535), is_first, is_last);
				end
				sent++;
			end
			lists++;
		end
		no_idle <= 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_threshold_extremes();
		test_table_overflow();
		test_output_backpressure();
		test_random_lists(1750);
		wait_results();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
